/* hdl/lkvc_pkg.sv */
`timescale 1ns / 1ps
package lkvc_pkg;

    // Field widths of the request and response items.
    localparam int REQ_KEY_W   = 32;
    localparam int REQ_VALUE_W = 32;
    localparam int RSP_VALUE_W = 32;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_SET = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_PROMOTE,
        ST_PROMOTE_END,
        ST_RESP
    } t_state;

endpackage

/* hdl/lkvc_req_if.sv */
`timescale 1ns / 1ps
interface lkvc_req_if;
    import lkvc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [REQ_KEY_W-1:0]   lookup_key;
    logic [REQ_VALUE_W-1:0] write_value;

    modport source (output valid, output op, output lookup_key, output write_value,
                    input ready);
    modport sink   (input valid, input op, input lookup_key, input write_value,
                    output ready);
endinterface

/* hdl/lkvc_rsp_if.sv */
`timescale 1ns / 1ps
interface lkvc_rsp_if;
    import lkvc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [RSP_VALUE_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

/* hdl/lkvc_slots.sv */
`timescale 1ns / 1ps
// Slot storage: key, value and recency rank memories, each with one
// registered read port and one write port.
module lkvc_slots #(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int IDX_W     = $clog2(ENTRIES),
    localparam int RANK_W    = $clog2(ENTRIES)
) (
    input  logic                  i_clk,
    input  logic [IDX_W-1:0]      i_rd_idx,
    output logic [KEY_BITS-1:0]   o_rd_key,
    output logic [VALUE_BITS-1:0] o_rd_value,
    output logic [RANK_W-1:0]     o_rd_rank,
    input  logic                  i_kv_we,
    input  logic [IDX_W-1:0]      i_kv_idx,
    input  logic [KEY_BITS-1:0]   i_wr_key,
    input  logic [VALUE_BITS-1:0] i_wr_value,
    input  logic                  i_rank_we,
    input  logic [IDX_W-1:0]      i_rank_idx,
    input  logic [RANK_W-1:0]     i_wr_rank
);
    logic [KEY_BITS-1:0]   r_key_mem   [ENTRIES];
    logic [VALUE_BITS-1:0] r_value_mem [ENTRIES];
    logic [RANK_W-1:0]     r_rank_mem  [ENTRIES];
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_BITS-1:0] r_rd_value;
    logic [RANK_W-1:0]     r_rd_rank;

    always_ff @(posedge i_clk) begin
        if (i_kv_we) begin
            r_key_mem[i_kv_idx]   <= i_wr_key;
            r_value_mem[i_kv_idx] <= i_wr_value;
        end
        r_rd_key   <= r_key_mem[i_rd_idx];
        r_rd_value <= r_value_mem[i_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_rank_we) begin
            r_rank_mem[i_rank_idx] <= i_wr_rank;
        end
        r_rd_rank <= r_rank_mem[i_rd_idx];
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_value = r_rd_value;
    assign o_rd_rank  = r_rd_rank;
endmodule

/* hdl/lru_key_value_cache.sv */
`timescale 1ns / 1ps
// Fully associative key-value cache with least-recently-used replacement.
// Each request item is a get or a set; each produces exactly one response
// item carrying a hit flag and, for a get hit, the stored value (zero on a
// get miss and on every set). After acceptance a request passes these
// steps: a sweep through the key memory compares one slot per cycle and
// tracks the hit, the first free slot and the eviction victim; the decide
// state picks the target slot and, for a set, writes the key and value; a
// second sweep rewrites the recency rank of every slot through the read
// port and the write port of the rank memory; and the response state loads
// the response once the output register is free. A get miss changes nothing
// and skips the second sweep. The sequencer passes through idle between
// requests, so a new request is accepted only after the previous response
// has been loaded. The request side is ready only while the sequencer is
// idle; a finished response sits in an output register, so the next request
// is accepted while it waits to be taken. Valid marks are flip-flops cleared
// by reset, so the cache is empty and usable as soon as reset is released,
// with no clearing pass.
module lru_key_value_cache #(
    parameter int ENTRIES    = 8,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lkvc_req_if.sink          i_req,
    lkvc_rsp_if.source        o_rsp
);
    import lkvc_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int RANK_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    t_state r_state;
    t_state n_state;

    // Latched request.
    t_op                   r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    // Sweep counter and its registered copy that lines up with the
    // registered memory read data.
    logic [IDX_W-1:0] r_idx;
    logic             r_pipe_vld;
    logic [IDX_W-1:0] r_pipe_idx;

    // Results gathered during the key sweep.
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [RANK_W-1:0]     r_hit_rank;
    logic [VALUE_BITS-1:0] r_hit_val;
    logic                  r_free_ok;
    logic [IDX_W-1:0]      r_free_idx;
    logic                  r_vic_ok;
    logic [IDX_W-1:0]      r_vic_idx;
    logic [RANK_W-1:0]     r_vic_rank;

    // Target of the recency update.
    logic [IDX_W-1:0]  r_tgt;
    logic [RANK_W-1:0] r_old_rank;
    logic              r_was_valid;

    logic [ENTRIES-1:0] r_valid;

    // Finished result and the output register.
    logic                   r_res_hit;
    logic [RSP_VALUE_W-1:0] r_res_val;
    logic                   r_out_vld;
    logic                   r_out_hit;
    logic [RSP_VALUE_W-1:0] r_out_val;

    logic [KEY_BITS-1:0]   w_rd_key;
    logic [VALUE_BITS-1:0] w_rd_value;
    logic [RANK_W-1:0]     w_rd_rank;

    logic              w_accept;
    logic              w_scan_step;
    logic              w_prom_step;
    logic              w_pipe_valid_slot;
    logic [IDX_W-1:0]  w_tgt;
    logic [RANK_W-1:0] w_old_rank;
    logic              w_was_valid;
    logic              w_is_set;
    logic              w_kv_we;
    logic [RANK_W-1:0] w_new_rank;
    logic              w_out_free;

    assign w_accept    = i_req.valid && i_req.ready;
    assign w_is_set    = (r_op == OP_SET);
    assign w_out_free  = !r_out_vld || o_rsp.ready;
    assign w_scan_step = r_pipe_vld && (r_state == ST_SCAN || r_state == ST_SCAN_END);
    assign w_prom_step = r_pipe_vld &&
                         (r_state == ST_PROMOTE || r_state == ST_PROMOTE_END);
    assign w_pipe_valid_slot = r_valid[r_pipe_idx];

    // A hit takes its own slot; a set miss takes the lowest free slot or,
    // when the cache is full, the slot with the highest rank.
    assign w_tgt       = r_hit ? r_hit_idx : (r_free_ok ? r_free_idx : r_vic_idx);
    assign w_old_rank  = r_hit ? r_hit_rank : r_vic_rank;
    assign w_was_valid = r_hit || !r_free_ok;
    assign w_kv_we     = (r_state == ST_DECIDE) && w_is_set;

    // New rank of the slot whose old rank has just been read.
    always_comb begin
        if (r_pipe_idx == r_tgt) begin
            w_new_rank = '0;
        end else if (w_pipe_valid_slot && (!r_was_valid || w_rd_rank < r_old_rank)) begin
            w_new_rank = w_rd_rank + RANK_W'(1);
        end else begin
            w_new_rank = w_rd_rank;
        end
    end

    lkvc_slots #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_slots (
        .i_clk      (i_clk),
        .i_rd_idx   (r_idx),
        .o_rd_key   (w_rd_key),
        .o_rd_value (w_rd_value),
        .o_rd_rank  (w_rd_rank),
        .i_kv_we    (w_kv_we),
        .i_kv_idx   (w_tgt),
        .i_wr_key   (r_key),
        .i_wr_value (r_value),
        .i_rank_we  (w_prom_step),
        .i_rank_idx (r_pipe_idx),
        .i_wr_rank  (w_new_rank)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                // A get miss leaves every slot as it was.
                n_state = (r_hit || w_is_set) ? ST_PROMOTE : ST_RESP;
            end
            ST_PROMOTE: begin
                if (r_idx == LAST_IDX) begin
                    n_state = ST_PROMOTE_END;
                end
            end
            ST_PROMOTE_END: begin
                n_state = ST_RESP;
            end
            ST_RESP: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Request latch, sweep counter and read pipeline.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_op'(i_req.op);
            r_key   <= KEY_BITS'(i_req.lookup_key);
            r_value <= VALUE_BITS'(i_req.write_value);
        end
        if (w_accept || r_state == ST_DECIDE) begin
            r_idx <= '0;
        end else if (r_state == ST_SCAN || r_state == ST_PROMOTE) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        r_pipe_idx <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pipe_vld <= 1'b0;
        end else begin
            r_pipe_vld <= (r_state == ST_SCAN) || (r_state == ST_PROMOTE);
        end
    end

    // Key sweep: one slot compared per cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_vic_ok  <= 1'b0;
        end else if (w_scan_step) begin
            if (w_pipe_valid_slot && w_rd_key == r_key && !r_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_pipe_idx;
                r_hit_rank <= w_rd_rank;
                r_hit_val  <= w_rd_value;
            end
            if (!w_pipe_valid_slot && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_pipe_idx;
            end
            // Strictly greater keeps the lowest-numbered slot on a tie.
            if (w_pipe_valid_slot && (!r_vic_ok || w_rd_rank > r_vic_rank)) begin
                r_vic_ok   <= 1'b1;
                r_vic_idx  <= r_pipe_idx;
                r_vic_rank <= w_rd_rank;
            end
        end
    end

    // Target selection and the result of this item.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DECIDE) begin
            r_tgt       <= w_tgt;
            r_old_rank  <= w_old_rank;
            r_was_valid <= w_was_valid;
            r_res_hit   <= r_hit;
            r_res_val   <= (r_hit && !w_is_set) ? RSP_VALUE_W'(r_hit_val) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_kv_we) begin
            r_valid[w_tgt] <= 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (r_state == ST_RESP && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESP && w_out_free) begin
            r_out_hit <= r_res_hit;
            r_out_val <= r_res_val;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.hit        = r_out_hit;
    assign o_rsp.read_value = r_out_val;

    // A slot once filled stays filled; entries are only ever replaced.
    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (($past(r_valid) & ~r_valid) == '0))
        else $error("valid mark cleared after reset");

    // A new response appears only from the response state of the sequencer.
    a_rsp_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && o_rsp.valid && (!$past(o_rsp.valid) || $past(o_rsp.ready)) &&
         $past(r_state) != ST_RESP) |-> 1'b0)
        else $error("response loaded outside the response state");

    // A miss never carries a value.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.hit) |-> (o_rsp.read_value == '0))
        else $error("miss response carries a nonzero value");

endmodule

/* bench/lru_key_value_cache_tb.sv */
`timescale 1ns / 1ps

import lkvc_pkg::*;

typedef struct packed {
    logic                   hit;
    logic [RSP_VALUE_W-1:0] read_value;
} t_cache_response;

class cache_mirror;
    localparam int SLOTS = 8;

    bit                   slot_valid [SLOTS];
    bit [REQ_KEY_W-1:0]   slot_key   [SLOTS];
    bit [REQ_VALUE_W-1:0] slot_value [SLOTS];
    bit [2:0]             slot_rank  [SLOTS];

    t_cache_response expected_responses [$];
    int              failures;

    function new();
        failures = 0;
        foreach (slot_valid[i]) begin
            slot_valid[i] = 1'b0;
        end
    endfunction

    function void report_failure(string msg);
        failures++;
        if (failures <= 10) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endfunction

    // Moves a slot to the front; newer slots (all, if it is new) step back one.
    function void make_recent(int slot, bit was_valid);
        bit [2:0] old_rank;
        old_rank = slot_rank[slot];
        for (int i = 0; i < SLOTS; i++) begin
            if (i != slot && slot_valid[i] && (!was_valid || slot_rank[i] < old_rank)) begin
                slot_rank[i]++;
            end
        end
        slot_rank[slot] = 3'd0;
    endfunction

    function void note_request(t_op op, logic [REQ_KEY_W-1:0] key,
                               logic [REQ_VALUE_W-1:0] value);
        t_cache_response rsp;
        int              found;
        int              slot;
        found = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_key[i] == key) begin
                found = i;
                break;
            end
        end
        rsp.hit        = (found >= 0);
        rsp.read_value = '0;
        if (op == OP_GET) begin
            if (found >= 0) begin
                rsp.read_value = slot_value[found];
                make_recent(found, 1'b1);
            end
        end else if (found >= 0) begin
            slot_value[found] = value;
            make_recent(found, 1'b1);
        end else begin
            slot = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!slot_valid[i]) begin
                    slot = i;
                    break;
                end
            end
            if (slot >= 0) begin
                make_recent(slot, 1'b0);
                slot_valid[slot] = 1'b1;
                slot_key[slot]   = key;
                slot_value[slot] = value;
            end else begin
                // Full: the slot with the highest rank is the least recently used.
                slot = 0;
                for (int i = 1; i < SLOTS; i++) begin
                    if (slot_rank[i] > slot_rank[slot]) begin
                        slot = i;
                    end
                end
                slot_key[slot]   = key;
                slot_value[slot] = value;
                make_recent(slot, 1'b1);
            end
        end
        expected_responses = {expected_responses, rsp};
    endfunction

    function void check_response(logic hit, logic [RSP_VALUE_W-1:0] read_value);
        t_cache_response want;
        if (expected_responses.size() == 0) begin
            report_failure($sformatf("unexpected response hit=%b read_value=%h",
                                     hit, read_value));
            return;
        end
        want = expected_responses.pop_front();
        if (hit !== want.hit) begin
            report_failure($sformatf("hit expected %b actual %b", want.hit, hit));
        end
        if (read_value !== want.read_value) begin
            report_failure($sformatf("read_value expected %h actual %h",
                                     want.read_value, read_value));
        end
    endfunction

    function int outstanding();
        return expected_responses.size();
    endfunction
endclass

module lru_key_value_cache_tb;

    // The drain after the last response is longer than the cache takes to
    // finish one request.
    localparam int CACHE_ENTRIES  = 8;
    localparam int DRAIN_CYCLES   = 2 * CACHE_ENTRIES + 10;
    localparam int RANDOM_ITEMS   = 800;
    // A correct run never stalls anywhere near this long between two accepted
    // items (sender gap, request processing, receiver stall), so this is generous.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_MAX       = 20;

    logic i_clk;
    logic i_rst_n;

    lkvc_req_if req_if ();
    lkvc_rsp_if rsp_if ();

    lru_key_value_cache #(
        .ENTRIES    (CACHE_ENTRIES),
        .KEY_BITS   (REQ_KEY_W),
        .VALUE_BITS (REQ_VALUE_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    cache_mirror mirror;
    int          stall_cycles = 0;
    int          req_burst_left;
    int          rsp_burst_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Each side waits a random gap, possibly none, before every item. Now
    // and then a burst of back-to-back items is drawn so the cache also sees
    // stretches with no idling on that side.
    function automatic int draw_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    // Presents one request item and returns at the edge where it is taken.
    // Valid stays high when the next item follows without a gap, so it is
    // never lowered and raised within the same time step.
    task automatic send_request(input t_op op, input logic [REQ_KEY_W-1:0] key,
                                input logic [REQ_VALUE_W-1:0] value);
        int gap;
        gap = draw_gap(req_burst_left);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.op          <= op;
        req_if.lookup_key  <= key;
        req_if.write_value <= value;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
    endtask

    // Monitor. Everything is sampled right after the rising edge, before any
    // nonblocking update of that edge lands, so the values seen are the ones
    // the cache saw. A response is checked before a request in the same cycle
    // is noted, since that response always belongs to an earlier request.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                mirror.check_response(rsp_if.hit, rsp_if.read_value);
            end
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                mirror.note_request(t_op'(req_if.op), req_if.lookup_key,
                                    req_if.write_value);
            end
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // Watchdog: too long without any item moving on either channel.
    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    // Response side: before every item ready may drop for a random gap,
    // independently of the request side.
    initial begin
        int gap;
        rsp_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = draw_gap(rsp_burst_left);
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_if.valid !== 1'b1);
        end
    end

    initial begin
        logic [REQ_KEY_W-1:0]   key_pool [POOL_MAX];
        int                     pool_size;
        logic [REQ_KEY_W-1:0]   key;
        logic [REQ_VALUE_W-1:0] value;
        t_op                    op;
        int                     roll;

        mirror         = new();
        req_burst_left = 0;
        rsp_burst_left = 0;
        pool_size      = 1;

        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.op          <= OP_GET;
        req_if.lookup_key  <= '0;
        req_if.write_value <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A get on the empty cache misses; extreme keys and
        // values go in and come back; a set on a present key overwrites it.
        send_request(OP_GET, 32'h0000_0000, 32'hDEAD_BEEF);
        send_request(OP_SET, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        send_request(OP_SET, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_SET, 32'h0000_0000, 32'h1234_5678);
        send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
        // Fill the remaining free slots, lowest free slot first.
        for (int k = 1; k <= 6; k++) begin
            send_request(OP_SET, REQ_KEY_W'(k), $urandom);
        end
        // A get hit reorders recency, then sets on a full cache evict the
        // least recently used entry, which must then miss.
        send_request(OP_GET, 32'h0000_0001, 32'h0);
        send_request(OP_SET, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(OP_SET, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
        send_request(OP_GET, 32'h0000_0002, 32'h0);
        send_request(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(OP_SET, 32'h0000_0001, 32'h8000_0001);
        send_request(OP_GET, 32'h0000_0001, 32'h0);
        send_request(OP_GET, 32'hA5A5_A5A5, 32'h0);
        send_request(OP_SET, 32'h0000_0007, 32'h7FFF_FFFF);
        send_request(OP_GET, 32'h0000_0003, 32'h0);

        // Random part. Most keys come from a small pool so hits, overwrites
        // and evictions are frequent; the pool size is redrawn every hundred
        // items, from smaller than the cache to well beyond it. The rest are
        // fully random keys that almost always miss.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case ($urandom_range(0, 4))
                    0: pool_size = 3;
                    1: pool_size = 8;
                    2: pool_size = 9;
                    3: pool_size = 12;
                    default: pool_size = POOL_MAX;
                endcase
                foreach (key_pool[i]) begin
                    key_pool[i] = $urandom;
                end
            end
            if ($urandom_range(0, 99) < 85) begin
                key = key_pool[$urandom_range(0, pool_size - 1)];
            end else begin
                key = $urandom;
            end
            op   = ($urandom_range(0, 99) < 55) ? OP_GET : OP_SET;
            roll = $urandom_range(0, 19);
            if (roll == 0) begin
                value = '0;
            end else if (roll == 1) begin
                value = '1;
            end else begin
                value = $urandom;
            end
            send_request(op, key, value);
        end
        req_if.valid <= 1'b0;

        // One more edge so the monitor has noted the last request, then wait
        // for every outstanding response and let the cache settle.
        @(posedge i_clk);
        while (mirror.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mirror.outstanding() != 0) begin
            mirror.report_failure("responses still expected at end of run");
        end

        if (mirror.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
